[sv/ckc_pkg.sv]
// ----------------------------------------------------------------------------
// ckc_pkg
// Shared types and constants of the canonical k-mer counter: table geometry,
// request codes, register indexes and the controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package ckc_pkg;

   // Table geometry: the suffix index holds TABLE_BASES bases, 2 bits each.
   localparam int TABLE_BASES = 8;
   localparam int IDX_W       = 2 * TABLE_BASES;
   localparam int TABLE_DEPTH = 1 << IDX_W;

   // Field widths.
   localparam int CODE_W    = 32;
   localparam int COUNT_W   = 32;
   localparam int BASES_W   = 5;
   localparam int MAX_BASES = 16;

   // Request codes.
   localparam logic [1:0] REQ_BASE = 2'd0;
   localparam logic [1:0] REQ_END  = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   // Register indexes.
   localparam logic [1:0] CSR_UNIT_SIZE    = 2'd0;
   localparam logic [1:0] CSR_PREFIX_SIZE  = 2'd1;
   localparam logic [1:0] CSR_PREFIX_VALUE = 2'd2;
   localparam logic [1:0] CSR_MIN_COUNT    = 2'd3;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CALC,
      ST_WRA,
      ST_WRB,
      ST_READ
   } state_type;

   // Saturating counter increment.
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] value);
      sat_inc = (value == {COUNT_W{1'b1}}) ? value : value + COUNT_W'(1);
   endfunction

endpackage

`default_nettype wire

[sv/ckc_ram.sv]
// ----------------------------------------------------------------------------
// ckc_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module ckc_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 65536,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[sv/canonical_kmer_counter.sv]
// ----------------------------------------------------------------------------
// canonical_kmer_counter
// Counts k-mers on both strands in one counter RAM and reads entries back, clearing each entry read.
// ----------------------------------------------------------------------------
// A base that completes a window keeps the block busy through the CALC, WRA and
// WRB states, set by two read-modify-write passes over the single counter RAM;
// any other base, end of sequence or unused request does not make it busy. A
// read request passes through the READ state, and its result strobe is registered
// in rsp_strobe_ff from the READ state held in state_ff. Results cannot be stalled.
// After reset the block sweeps all 65536 counter RAM entries to zero, busy high.
`default_nettype none

module canonical_kmer_counter
   import ckc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_type,
   input  wire logic [7:0]         req_base_char,
   input  wire logic [15:0]        req_entry_index,
   output logic                    rsp_strobe,
   output logic      [CODE_W-1:0]  rsp_kmer_code,
   output logic      [COUNT_W-1:0] rsp_kmer_count,
   output logic                    rsp_is_nonzero,
   output logic                    rsp_meets_min,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data
);

   // Configuration registers.
   logic [4:0]         unit_size_ff;
   logic [4:0]         prefix_size_ff;
   logic [CODE_W-1:0]  prefix_value_ff;
   logic [COUNT_W-1:0] threshold_ff;

   // Control and datapath state.
   state_type          state_ff, state_in;
   logic [CODE_W-1:0]  window_ff, window_in;
   logic [BASES_W-1:0] bases_ff, bases_in;
   logic [IDX_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [IDX_W-1:0]   idx_a_ff, idx_a_in;
   logic [IDX_W-1:0]   idx_b_ff, idx_b_in;
   logic               hit_a_ff, hit_a_in;
   logic               hit_b_ff, hit_b_in;
   logic [COUNT_W-1:0] fwd_val_ff, fwd_val_in;

   // Result registers.
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [CODE_W-1:0]  rsp_code_ff, rsp_code_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_nonzero_ff, rsp_nonzero_in;
   logic               rsp_meets_ff, rsp_meets_in;

   // Counter RAM port signals.
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [COUNT_W-1:0] mem_wdata;
   logic [IDX_W-1:0]   mem_raddr;
   logic [COUNT_W-1:0] mem_rdata;

   // Combinational helpers.
   logic               accept;
   logic [4:0]         u_eff, p_eff, s_eff;
   logic [CODE_W-1:0]  mask_u, mask_s, mask_p, pfx;
   logic               char_valid;
   logic [1:0]         char_code;
   logic [CODE_W-1:0]  fwd_code, comp_code, rev16, rev_code;
   logic [5:0]         rev_shift;
   logic               hit_f, hit_r;
   logic [CODE_W-1:0]  idx_f32, idx_r32, req_idx32, rsp_idx32;
   logic [COUNT_W-1:0] b_old;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Effective sizes: unit size clamped to 1..16, prefix no longer than it.
   always_comb begin
      if (unit_size_ff == 5'd0) begin
         u_eff = 5'd1;
      end else if (unit_size_ff > 5'(MAX_BASES)) begin
         u_eff = 5'(MAX_BASES);
      end else begin
         u_eff = unit_size_ff;
      end
      p_eff = (prefix_size_ff > u_eff) ? u_eff : prefix_size_ff;
      s_eff = u_eff - p_eff;
   end

   // Masks over 2 bits per base; a shift by 32 gives an all-ones mask.
   assign mask_u = ~({CODE_W{1'b1}} << {u_eff, 1'b0});
   assign mask_s = ~({CODE_W{1'b1}} << {s_eff, 1'b0});
   assign mask_p = ~({CODE_W{1'b1}} << {p_eff, 1'b0});
   assign pfx    = prefix_value_ff & mask_p;

   // Nucleotide decode, either case.
   always_comb begin
      char_valid = 1'b1;
      char_code  = 2'd0;
      case (req_base_char)
         8'h41, 8'h61: char_code = 2'd0;
         8'h43, 8'h63: char_code = 2'd1;
         8'h47, 8'h67: char_code = 2'd2;
         8'h54, 8'h74: char_code = 2'd3;
         default:      char_valid = 1'b0;
      endcase
   end

   // Forward code and its reverse complement from the stored window.
   always_comb begin
      fwd_code  = window_ff & mask_u;
      comp_code = ~window_ff & mask_u;
      for (int i = 0; i < MAX_BASES; i++) begin
         rev16[2*i +: 2] = comp_code[2*(MAX_BASES-1-i) +: 2];
      end
      rev_shift = 6'd32 - {u_eff, 1'b0};
      rev_code  = rev16 >> rev_shift;
      hit_f     = ((fwd_code >> {s_eff, 1'b0}) == pfx);
      hit_r     = ((rev_code >> {s_eff, 1'b0}) == pfx);
      idx_f32   = fwd_code & mask_s;
      idx_r32   = rev_code & mask_s;
   end

   assign req_idx32 = CODE_W'(req_entry_index);
   assign rsp_idx32 = CODE_W'(idx_a_ff);

   // The second pass sees the first pass's write when both hit one entry.
   assign b_old = (hit_a_ff && (idx_a_ff == idx_b_ff)) ? fwd_val_ff : mem_rdata;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == {IDX_W{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_BASE: begin
                     if (char_valid && (bases_in >= u_eff)) begin
                        state_in = ST_CALC;
                     end
                  end
                  REQ_READ: state_in = ST_READ;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_CALC: state_in = ST_WRA;
         ST_WRA:  state_in = ST_WRB;
         ST_WRB:  state_in = ST_IDLE;
         ST_READ: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Counter RAM access per state.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_a_ff;
      mem_wdata = '0;
      mem_raddr = req_idx32[IDX_W-1:0];
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
         end
         ST_CALC: begin
            mem_raddr = idx_f32[IDX_W-1:0];
         end
         ST_WRA: begin
            mem_we    = hit_a_ff;
            mem_wdata = sat_inc(mem_rdata);
            mem_raddr = idx_b_ff;
         end
         ST_WRB: begin
            mem_we    = hit_b_ff;
            mem_waddr = idx_b_ff;
            mem_wdata = sat_inc(b_old);
         end
         ST_READ: begin
            mem_we = 1'b1;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Window, pass bookkeeping and result values.
   always_comb begin
      window_in      = window_ff;
      bases_in       = bases_ff;
      clr_addr_in    = clr_addr_ff + IDX_W'(1);
      idx_a_in       = idx_a_ff;
      idx_b_in       = idx_b_ff;
      hit_a_in       = hit_a_ff;
      hit_b_in       = hit_b_ff;
      fwd_val_in     = sat_inc(mem_rdata);
      rsp_strobe_in  = (state_ff == ST_READ);
      rsp_code_in    = (pfx << {s_eff, 1'b0}) | (rsp_idx32 & mask_s);
      rsp_count_in   = mem_rdata;
      rsp_nonzero_in = (mem_rdata != '0);
      rsp_meets_in   = (mem_rdata >= threshold_ff);

      // Base request: shift in a valid base; an invalid base or an end request empties the window.
      if (req_type == REQ_BASE && char_valid) begin
         window_in = {window_ff[CODE_W-3:0], char_code};
         bases_in  = (bases_ff < BASES_W'(MAX_BASES)) ? bases_ff + BASES_W'(1) : bases_ff;
      end else begin
         window_in = '0;
         bases_in  = '0;
      end
      if (!(accept && (req_type == REQ_BASE || req_type == REQ_END))) begin
         window_in = window_ff;
         bases_in  = bases_ff;
      end

      // A read request keeps its entry index for the clear and the result.
      if (accept && req_type == REQ_READ) begin
         idx_a_in = req_idx32[IDX_W-1:0];
      end

      // Latch both strand indexes and their prefix hits.
      if (state_ff == ST_CALC) begin
         idx_a_in = idx_f32[IDX_W-1:0];
         idx_b_in = idx_r32[IDX_W-1:0];
         hit_a_in = hit_f;
         hit_b_in = hit_r;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_addr_ff     <= '0;
         window_ff       <= '0;
         bases_ff        <= '0;
         rsp_strobe_ff   <= 1'b0;
         unit_size_ff    <= 5'd8;
         prefix_size_ff  <= 5'd0;
         prefix_value_ff <= '0;
         threshold_ff    <= COUNT_W'(1);
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         window_ff     <= window_in;
         bases_ff      <= bases_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_we) begin
            case (csr_index)
               CSR_UNIT_SIZE:    unit_size_ff    <= csr_data[4:0];
               CSR_PREFIX_SIZE:  prefix_size_ff  <= csr_data[4:0];
               CSR_PREFIX_VALUE: prefix_value_ff <= csr_data;
               CSR_MIN_COUNT:    threshold_ff    <= csr_data;
               default:          unit_size_ff    <= unit_size_ff;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_a_ff   <= idx_a_in;
      idx_b_ff   <= idx_b_in;
      hit_a_ff   <= hit_a_in;
      hit_b_ff   <= hit_b_in;
      fwd_val_ff <= fwd_val_in;
      if (state_ff == ST_READ) begin
         rsp_code_ff    <= rsp_code_in;
         rsp_count_ff   <= rsp_count_in;
         rsp_nonzero_ff <= rsp_nonzero_in;
         rsp_meets_ff   <= rsp_meets_in;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_kmer_code  = rsp_code_ff;
   assign rsp_kmer_count = rsp_count_ff;
   assign rsp_is_nonzero = rsp_nonzero_ff;
   assign rsp_meets_min  = rsp_meets_ff;

   // Counter table.
   ckc_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // A result follows only a read-and-clear pass.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff) == ST_READ)
      else $error("result strobe without a read request");

   // The second counter pass always directly follows the first one.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRB |-> $past(state_ff) == ST_WRA)
      else $error("second pass out of order");

   // The table is never written while the block waits for a request.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mem_we)
      else $error("counter write while idle");

   // The base count saturates at the window length.
   assert property (@(posedge clock) disable iff (reset)
      bases_ff <= BASES_W'(MAX_BASES))
      else $error("base count beyond window length");

endmodule

`default_nettype wire
